/* rtl/tpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpt_pkg
// Shared widths, state codes and scan status for the tag presence table.
// ---------------------------------------------------------------------------
package tpt_pkg;

  localparam int TAG_BYTES  = 12;
  localparam int TAG_W      = TAG_BYTES * 8;
  localparam int LOW_W      = 64;
  localparam int HIGH_W     = TAG_W - LOW_W;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 16;
  localparam int IN_DATA_W  = TAG_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_PACK_W = SLOT_W + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_PACK_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 3;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  typedef struct packed {
    logic done;
    logic hit;
    logic dead_found;
  } scan_res_t;

endpackage : tpt_pkg
`default_nettype wire

/* rtl/tpt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tpt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule : tpt_ram
`default_nettype wire

/* rtl/tpt_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpt_seq
// Scan sequencer: walks the ID table one entry per cycle through the RAM
// read port and one shared 96-bit comparator, tracking the first dead entry.
// ---------------------------------------------------------------------------
module tpt_seq
  import tpt_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int IDX_W   = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [TAG_W-1:0]   tag,
  input  wire logic [ENTRIES-1:0] live,
  input  wire logic [ENTRIES-1:0] written,
  input  wire logic [TAG_W-1:0]   rd_data,
  output logic      [IDX_W-1:0]   rd_addr,
  output scan_res_t               res,
  output logic      [IDX_W-1:0]   hit_idx,
  output logic      [IDX_W-1:0]   dead_idx
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  logic             busy_r, busy_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic [IDX_W-1:0] iss_r, iss_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             dead_found_r, dead_found_nxt;
  logic [IDX_W-1:0] dead_idx_r, dead_idx_nxt;
  logic             done_r, done_nxt;
  logic             hit_r, hit_nxt;
  logic [TAG_W-1:0] entry_id;
  logic             eq;

  // never-written entries read as zero
  assign entry_id = written[cmp_idx_r] ? rd_data : '0;
  assign eq       = (entry_id == tag);

  always_comb begin
    busy_nxt       = busy_r;
    iss_done_nxt   = iss_done_r;
    iss_nxt        = iss_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    dead_found_nxt = dead_found_r;
    dead_idx_nxt   = dead_idx_r;
    done_nxt       = 1'b0;
    hit_nxt        = hit_r;
    if (start) begin
      busy_nxt       = 1'b1;
      iss_done_nxt   = 1'b0;
      iss_nxt        = '0;
      cmp_vld_nxt    = 1'b0;
      dead_found_nxt = 1'b0;
    end else if (busy_r) begin
      cmp_vld_nxt = !iss_done_r;
      cmp_idx_nxt = iss_r;
      if (iss_r == LAST) begin
        iss_done_nxt = 1'b1;
      end else begin
        iss_nxt = iss_r + IDX_W'(1);
      end
      if (cmp_vld_r) begin
        if (!live[cmp_idx_r] && !dead_found_r) begin
          dead_found_nxt = 1'b1;
          dead_idx_nxt   = cmp_idx_r;
        end
        if (eq || (cmp_idx_r == LAST)) begin
          busy_nxt    = 1'b0;
          cmp_vld_nxt = 1'b0;
          cmp_idx_nxt = cmp_idx_r;
          done_nxt    = 1'b1;
          hit_nxt     = eq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      iss_done_r   <= 1'b0;
      iss_r        <= '0;
      cmp_vld_r    <= 1'b0;
      cmp_idx_r    <= '0;
      dead_found_r <= 1'b0;
      dead_idx_r   <= '0;
      done_r       <= 1'b0;
      hit_r        <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      iss_done_r   <= iss_done_nxt;
      iss_r        <= iss_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      dead_found_r <= dead_found_nxt;
      dead_idx_r   <= dead_idx_nxt;
      done_r       <= done_nxt;
      hit_r        <= hit_nxt;
    end
  end

  assign rd_addr        = iss_r;
  assign res.done       = done_r;
  assign res.hit        = hit_r;
  assign res.dead_found = dead_found_r;
  assign hit_idx        = cmp_idx_r;
  assign dead_idx       = dead_idx_r;

endmodule : tpt_seq
`default_nettype wire

/* rtl/tag_presence_toggle_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tag_presence_toggle_table_core
// Presence table for 96-bit tag IDs: toggles a tag between live and dead and
// keeps wrapping counts of regular and diagnostic reads that do not find the table full.
// ---------------------------------------------------------------------------
// One word is taken at a time. After a word is accepted the block scans the
// ID table one entry per cycle through a single RAM read port and a single
// 96-bit comparator, stopping at the first matching entry or at the last one.
// RAM read data and the scan's done flag are registered; the result then goes
// through the ST_OUT state, which waits while an untaken result is held, into
// the output register. in_tready is low until then and returns high as the
// result is loaded; the result then waits there until taken while the next
// word may already be scanned. Live and written marks are flops cleared by
// reset, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module tag_presence_toggle_table_core
  import tpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // tag_id_low, tag_id_high
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // diag_mode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // slot, regular_total, diag_total
  output logic      [OUT_USER_W-1:0] out_tuser   // exiting, diag_event, table_full
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [1:0]               state_r, state_nxt;
  logic [TAG_W-1:0]         tag_r;
  logic                     diag_r;
  logic [TABLE_ENTRIES-1:0] live_r, live_nxt;
  logic [TABLE_ENTRIES-1:0] written_r, written_nxt;
  logic [CNT_W-1:0]         reg_cnt_r, reg_cnt_nxt;
  logic [CNT_W-1:0]         diag_cnt_r, diag_cnt_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [SLOT_W-1:0]        out_slot_r, out_slot_nxt;
  logic                     out_exit_r, out_exit_nxt;
  logic                     out_diag_r, out_diag_nxt;
  logic                     out_full_r, out_full_nxt;
  logic [CNT_W-1:0]         out_reg_r, out_reg_nxt;
  logic [CNT_W-1:0]         out_dcnt_r, out_dcnt_nxt;

  logic                     in_acc;
  logic                     load;
  logic                     hit_live;
  logic [IDX_W-1:0]         target;
  logic                     wr_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [TAG_W-1:0]         rd_data;
  scan_res_t                res;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         dead_idx;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load      = (state_r == ST_OUT) && (!out_vld_r || out_tready);
  assign hit_live  = res.hit && live_r[hit_idx];
  assign target    = res.hit ? hit_idx : dead_idx;
  assign wr_en     = load && !hit_live && (res.hit || res.dead_found);

  tpt_seq #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .tag      (tag_r),
    .live     (live_r),
    .written  (written_r),
    .rd_data  (rd_data),
    .rd_addr  (rd_addr),
    .res      (res),
    .hit_idx  (hit_idx),
    .dead_idx (dead_idx)
  );

  tpt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (target),
    .wr_data (tag_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    live_nxt     = live_r;
    written_nxt  = written_r;
    reg_cnt_nxt  = reg_cnt_r;
    diag_cnt_nxt = diag_cnt_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_slot_nxt = out_slot_r;
    out_exit_nxt = out_exit_r;
    out_diag_nxt = out_diag_r;
    out_full_nxt = out_full_r;
    out_reg_nxt  = out_reg_r;
    out_dcnt_nxt = out_dcnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (res.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load) begin
          state_nxt    = ST_IDLE;
          out_vld_nxt  = 1'b1;
          out_diag_nxt = diag_r;
          out_exit_nxt = hit_live;
          out_full_nxt = 1'b0;
          if (hit_live) begin
            live_nxt[hit_idx] = 1'b0;
            out_slot_nxt      = SLOT_W'(hit_idx);
          end else if (wr_en) begin
            live_nxt[target]    = 1'b1;
            written_nxt[target] = 1'b1;
            out_slot_nxt        = SLOT_W'(target);
          end else begin
            out_full_nxt = 1'b1;
            out_slot_nxt = '0;
          end
          if (hit_live || wr_en) begin
            if (diag_r) begin
              diag_cnt_nxt = diag_cnt_r + CNT_W'(1);
            end else begin
              reg_cnt_nxt = reg_cnt_r + CNT_W'(1);
            end
          end
          out_reg_nxt  = reg_cnt_nxt;
          out_dcnt_nxt = diag_cnt_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      live_r     <= '0;
      written_r  <= '0;
      reg_cnt_r  <= '0;
      diag_cnt_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      live_r     <= live_nxt;
      written_r  <= written_nxt;
      reg_cnt_r  <= reg_cnt_nxt;
      diag_cnt_r <= diag_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_r  <= in_tdata[TAG_W-1:0];
      diag_r <= in_tuser[0];
    end
    out_slot_r <= out_slot_nxt;
    out_exit_r <= out_exit_nxt;
    out_diag_r <= out_diag_nxt;
    out_full_r <= out_full_nxt;
    out_reg_r  <= out_reg_nxt;
    out_dcnt_r <= out_dcnt_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'({out_dcnt_r, out_reg_r, out_slot_r});
  assign out_tuser  = {out_full_r, out_diag_r, out_exit_r};

endmodule : tag_presence_toggle_table_core
`default_nettype wire

/* rtl/tpt_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpt_chk
// Port-level checks for the tag presence table, bound to the top level.
// ---------------------------------------------------------------------------
module tpt_chk
  import tpt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // full table reports slot 0 and no exit
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> (out_tdata[SLOT_W-1:0] == '0) && !out_tuser[0])
    else $error("full-table word carries a slot or an exit");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while scanning");

  // a new result only comes out of a scan
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a scan");

endmodule : tpt_chk

bind tag_presence_toggle_table_core tpt_chk u_tpt_chk (.*);
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Streams tag reads into tag_presence_toggle_table_core under random idling
// on both sides and checks every result word against a local presence-table
// predictor.
// ---------------------------------------------------------------------------
module testbench;
  import tpt_pkg::*;

  localparam int ENTRIES      = 8;
  localparam int RANDOM_READS = 1400;
  localparam int POOL_SIZE    = 6;
  localparam int DRAIN_AT     = 700;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 3 * (ENTRIES + 5);

  typedef struct {
    logic [LOW_W-1:0]  id_low;
    logic [HIGH_W-1:0] id_high;
    logic              diag;
    logic              hold_until_drained;
  } tag_read_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              exiting;
    logic              diag_event;
    logic              table_full;
    logic [CNT_W-1:0]  regular_total;
    logic [CNT_W-1:0]  diag_total;
  } presence_result_t;

  typedef struct {
    logic [LOW_W-1:0]  id_low[ENTRIES];
    logic [HIGH_W-1:0] id_high[ENTRIES];
    logic              live[ENTRIES];
    logic [CNT_W-1:0]  regular_count;
    logic [CNT_W-1:0]  diag_count;
  } presence_table_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // tag_id_low, tag_id_high
  logic [IN_USER_W-1:0]  in_tuser   = '0;  // diag_mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // slot, regular_total, diag_total
  logic [OUT_USER_W-1:0] out_tuser;        // exiting, diag_event, table_full

  tag_read_t        pending_reads[$];
  presence_result_t expected_results[$];
  presence_table_t  shadow_table;
  presence_table_t  plan_table;
  logic [TAG_W-1:0] tag_pool[POOL_SIZE];

  int n_reads_taken  = 0;
  int reads_launched = 0;
  int n_results      = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int in_gap         = 0;
  int out_wait       = 0;
  int long_hold      = 0;

  tag_presence_toggle_table_core #(
    .TABLE_ENTRIES(ENTRIES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic void clear_table(inout presence_table_t t);
    for (int i = 0; i < ENTRIES; i++) begin
      t.id_low[i]  = '0;
      t.id_high[i] = '0;
      t.live[i]    = 1'b0;
    end
    t.regular_count = '0;
    t.diag_count    = '0;
  endfunction

  // first match on all 96 bits wins; a live match exits, otherwise the tag
  // reuses its dead match or takes the lowest dead entry
  function automatic presence_result_t apply_read(inout presence_table_t t,
                                                  input tag_read_t rd);
    presence_result_t r;
    int               hit;
    int               target;
    r = '0;
    hit = -1;
    target = -1;
    r.diag_event = rd.diag;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && t.id_low[i] == rd.id_low && t.id_high[i] == rd.id_high) hit = i;
    end
    if (hit >= 0 && t.live[hit]) begin
      t.live[hit] = 1'b0;
      r.slot      = SLOT_W'(hit);
      r.exiting   = 1'b1;
    end else begin
      target = hit;
      for (int i = 0; i < ENTRIES; i++) begin
        if (target < 0 && !t.live[i]) target = i;
      end
      if (target < 0) begin
        r.table_full = 1'b1;
      end else begin
        t.id_low[target]  = rd.id_low;
        t.id_high[target] = rd.id_high;
        t.live[target]    = 1'b1;
        r.slot            = SLOT_W'(target);
      end
    end
    if (!r.table_full) begin
      if (rd.diag) t.diag_count = t.diag_count + CNT_W'(1);
      else t.regular_count = t.regular_count + CNT_W'(1);
    end
    r.regular_total = t.regular_count;
    r.diag_total    = t.diag_count;
    return r;
  endfunction

  function automatic logic [TAG_W-1:0] random_tag();
    return {$urandom, $urandom, $urandom};
  endfunction

  task automatic add_read(input logic [TAG_W-1:0] tag, input logic diag,
                          input logic hold = 1'b0);
    tag_read_t rd;
    rd.id_low             = tag[LOW_W-1:0];
    rd.id_high            = tag[TAG_W-1:LOW_W];
    rd.diag               = diag;
    rd.hold_until_drained = hold;
    void'(apply_read(plan_table, rd));
    pending_reads.push_back(rd);
  endtask

  // sender: one word in flight until its handshake, then a random gap
  always @(negedge clk) begin
    tag_read_t rd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && n_reads_taken != reads_launched)) begin
      if (in_tvalid) in_gap = ((n_reads_taken / 128) % 4 == 1) ? 0 : $urandom_range(0, 5);
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_reads.size() != 0 &&
                   !(pending_reads[0].hold_until_drained && expected_results.size() != 0)) begin
        rd = pending_reads.pop_front();
        in_tdata  <= {rd.id_high, rd.id_low};
        in_tuser  <= rd.diag;
        in_tvalid <= 1'b1;
        reads_launched++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall per result word, one long hold-off
  always @(negedge clk) begin
    if (results_seen != n_results) begin
      results_seen = n_results;
      out_wait = ((n_results / 150) % 4 == 2) ? 0 : $urandom_range(0, 5);
      if (n_results == HOLD_AT) long_hold = HOLD_LEN;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      if (out_tvalid) out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    presence_result_t got;
    presence_result_t want;
    tag_read_t        rd;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.slot          = out_tdata[SLOT_W-1:0];
        got.regular_total = out_tdata[SLOT_W +: CNT_W];
        got.diag_total    = out_tdata[SLOT_W+CNT_W +: CNT_W];
        got.exiting       = out_tuser[0];
        got.diag_event    = out_tuser[1];
        got.table_full    = out_tuser[2];
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result word %0d with nothing expected: slot %0d exit %0b",
                     n_results, got.slot, got.exiting);
        end else begin
          want = expected_results.pop_front();
          if (got.slot !== want.slot || got.exiting !== want.exiting ||
              got.diag_event !== want.diag_event || got.table_full !== want.table_full ||
              got.regular_total !== want.regular_total ||
              got.diag_total !== want.diag_total) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: word %0d exp slot %0d exit %0b diag %0b full %0b reg %0d ",
                        "dcnt %0d / got slot %0d exit %0b diag %0b full %0b reg %0d dcnt %0d"},
                       n_results, want.slot, want.exiting, want.diag_event, want.table_full,
                       want.regular_total, want.diag_total, got.slot, got.exiting,
                       got.diag_event, got.table_full, got.regular_total, got.diag_total);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        rd.id_low             = in_tdata[LOW_W-1:0];
        rd.id_high            = in_tdata[TAG_W-1:LOW_W];
        rd.diag               = in_tuser[0];
        rd.hold_until_drained = 1'b0;
        expected_results.push_back(apply_read(shadow_table, rd));
        n_reads_taken++;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [TAG_W-1:0] ones;
    logic [TAG_W-1:0] r1;
    logic [TAG_W-1:0] r2;
    logic [TAG_W-1:0] r3;
    logic [TAG_W-1:0] tag;
    int               live_idx[$];
    int               pick;
    int               k;

    clear_table(shadow_table);
    clear_table(plan_table);
    ones = '1;
    r1 = random_tag();
    r2 = random_tag();
    r3 = random_tag();

    // zero tag hits the dead all-zero entry 0, then leaves again
    add_read('0, 1'b0);
    add_read('0, 1'b1);
    // fill with tags one bit apart at the field boundaries
    add_read(ones, 1'b1);
    add_read(ones ^ (96'b1 << 95), 1'b0);
    add_read(ones ^ (96'b1 << 64), 1'b0);
    add_read(ones ^ (96'b1 << 63), 1'b1);
    add_read(ones ^ 96'b1, 1'b0);
    add_read(r1, 1'b0);
    add_read(r2, 1'b1);
    add_read('0, 1'b0);               // reuses the never-written zero entry 7
    add_read(r3, 1'b1);               // full table
    add_read('0, 1'b0);
    add_read(ones ^ 96'b1, 1'b1);
    add_read(ones, 1'b0);
    add_read(ones ^ 96'b1, 1'b0);     // own dead slot, not the lowest dead one
    add_read(r3, 1'b0);
    add_read(ones, 1'b1);
    add_read('0, 1'b1);               // full again
    add_read(r1, 1'b0);
    add_read('0, 1'b0);

    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = random_tag();
    for (int n = 0; n < RANDOM_READS; n++) begin
      if (n % 200 == 199) tag_pool[$urandom_range(0, POOL_SIZE - 1)] = random_tag();
      live_idx.delete();
      for (int i = 0; i < ENTRIES; i++) if (plan_table.live[i]) live_idx.push_back(i);
      pick = $urandom_range(0, 99);
      if (pick < 40 && live_idx.size() != 0) begin
        k = live_idx[$urandom_range(0, live_idx.size() - 1)];
        tag = {plan_table.id_high[k], plan_table.id_low[k]};
      end else if (pick < 70) begin
        tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 88) begin
        tag = random_tag();
      end else if (pick < 95) begin
        k = $urandom_range(0, ENTRIES - 1);
        tag = {plan_table.id_high[k], plan_table.id_low[k]} ^ (96'b1 << $urandom_range(0, 95));
      end else begin
        tag = '0;
      end
      add_read(tag, 1'($urandom_range(0, 1)), n == DRAIN_AT);
    end

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    while (pending_reads.size() != 0 || n_reads_taken != reads_launched ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
